@@ rtl/core/ale_pkg.sv @@
// ----------------------------------------------------------------------------
// ale_pkg
// Shared types, codes and default sizes for the array list engine.
// ----------------------------------------------------------------------------
`default_nettype none

package ale_pkg;

	localparam int ALE_CAPACITY      = 128;
	localparam int ALE_ELEMENT_WIDTH = 32;

	typedef enum logic [2:0] {
		OP_READ    = 3'd0,
		OP_REPLACE = 3'd1,
		OP_INSERT  = 3'd2,
		OP_DELETE  = 3'd3,
		OP_FIND    = 3'd4,
		OP_CLEAR   = 3'd5
	} ale_op_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_INS_REJ   = 2'd1,
		ST_ACC_REJ   = 2'd2,
		ST_NOT_FOUND = 2'd3
	} ale_status_t;

	typedef struct packed {
		logic [2:0]         kind;
		logic [7:0]         position;
		logic signed [31:0] value;
	} ale_req_t;

	typedef struct packed {
		logic signed [31:0] read_value;
		logic [6:0]         found_position;
		logic [7:0]         count;
		logic [1:0]         status;
	} ale_rsp_t;

endpackage

`default_nettype wire

@@ rtl/core/array_list_engine.sv @@
// ----------------------------------------------------------------------------
// array_list_engine
// Ordered list held in one synchronous memory with an entry count.
//
//   channel | direction | beat      | handshake
//   req     | in        | ale_req_t | req_valid / req_ready
//   rsp     | out       | ale_rsp_t | rsp_valid / rsp_ready
//
// One beat in, one beat out. A read goes through S_RD_WAIT; replace, clear, invalid
// operations, inserts and deletes at the tail and finds on an empty list answer from S_IDLE.
// Insert and delete move one entry per cycle through the memory, an insert through
// S_SHIFT, S_DRAIN and S_PUT and a delete through S_SHIFT and S_DRAIN;
// find checks one entry per cycle in S_FIND, then S_FIND_LAST.
// Reset clears the count; memory contents need no clearing.
// A waiting response holds off the next request until it is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module array_list_engine #(
	parameter int CAPACITY      = ale_pkg::ALE_CAPACITY,
	parameter int ELEMENT_WIDTH = ale_pkg::ALE_ELEMENT_WIDTH
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              req_valid,
	output logic                   req_ready,
	input  wire ale_pkg::ale_req_t req_data,
	output logic                   rsp_valid,
	input  wire logic              rsp_ready,
	output ale_pkg::ale_rsp_t      rsp_data
);

	import ale_pkg::*;

	localparam int AW   = $clog2(CAPACITY);
	localparam int CW   = $clog2(CAPACITY + 1);
	localparam int CMPW = (CW > 8) ? CW : 8;
	localparam int EW   = ELEMENT_WIDTH;

	typedef enum logic [2:0] {
		S_IDLE,
		S_RD_WAIT,
		S_SHIFT,
		S_DRAIN,
		S_PUT,
		S_FIND,
		S_FIND_LAST
	} state_t;

	state_t            state_q;
	ale_op_t           op_q;
	logic [AW-1:0]     idx_q;
	logic [AW-1:0]     pos_q;
	logic [EW-1:0]     val_q;
	logic [CW-1:0]     cnt_q;
	logic              rsp_valid_q;
	ale_rsp_t          rsp_q;

	logic              shift_vld_s1;
	logic [AW-1:0]     shift_waddr_s1;
	logic              find_vld_s1;
	logic [AW-1:0]     find_idx_s1;
	logic [EW-1:0]     rd_data_s1;

	logic [EW-1:0]     mem [CAPACITY];

	logic              accept;
	logic [CMPW-1:0]   pos_c;
	logic [CMPW-1:0]   cnt_c;
	logic              acc_ok;
	logic              ins_ok;
	logic              tail_ins;
	logic              tail_del;
	logic [EW-1:0]     elem_in;
	logic [CW-1:0]     cnt_m1;
	logic              find_hit;

	logic              mem_we;
	logic [AW-1:0]     mem_waddr;
	logic [EW-1:0]     mem_wdata;
	logic [AW-1:0]     mem_raddr;

	assign req_ready = (state_q == S_IDLE) && (!rsp_valid_q || rsp_ready);
	assign accept    = req_valid && req_ready;
	assign rsp_valid = rsp_valid_q;
	assign rsp_data  = rsp_q;

	always_comb begin
		pos_c    = CMPW'(req_data.position);
		cnt_c    = CMPW'(cnt_q);
		acc_ok   = pos_c < cnt_c;
		ins_ok   = (cnt_c < CMPW'(CAPACITY)) && (pos_c <= cnt_c);
		tail_ins = pos_c == cnt_c;
		tail_del = (pos_c + CMPW'(1)) == cnt_c;
		elem_in  = EW'($unsigned(req_data.value));
		cnt_m1   = cnt_q - CW'(1);
		find_hit = find_vld_s1 && (rd_data_s1 == val_q);
	end

	// memory port control
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = shift_waddr_s1;
		mem_wdata = rd_data_s1;
		mem_raddr = (state_q == S_IDLE) ? AW'(req_data.position) : idx_q;
		if (shift_vld_s1) begin
			mem_we = 1'b1;
		end else if (state_q == S_PUT) begin
			mem_we    = 1'b1;
			mem_waddr = pos_q;
			mem_wdata = val_q;
		end else if (accept) begin
			mem_waddr = AW'(req_data.position);
			mem_wdata = elem_in;
			if (req_data.kind == OP_REPLACE && acc_ok) begin
				mem_we = 1'b1;
			end else if (req_data.kind == OP_INSERT && ins_ok && tail_ins) begin
				mem_we = 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		rd_data_s1 <= mem[mem_raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			op_q           <= OP_READ;
			idx_q          <= '0;
			pos_q          <= '0;
			val_q          <= '0;
			cnt_q          <= '0;
			rsp_valid_q    <= 1'b0;
			rsp_q          <= '0;
			shift_vld_s1   <= 1'b0;
			shift_waddr_s1 <= '0;
			find_vld_s1    <= 1'b0;
			find_idx_s1    <= '0;
		end else begin
			if (rsp_valid_q && rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
			shift_vld_s1 <= 1'b0;
			find_vld_s1  <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						op_q  <= ale_op_t'(req_data.kind);
						pos_q <= AW'(req_data.position);
						val_q <= elem_in;
						rsp_q <= '{read_value: '0, found_position: '0,
							count: 8'(cnt_q), status: ST_OK};
						rsp_valid_q <= 1'b1;
						unique case (req_data.kind)
							OP_READ: begin
								if (acc_ok) begin
									rsp_valid_q <= 1'b0;
									state_q     <= S_RD_WAIT;
								end else begin
									rsp_q.status <= ST_ACC_REJ;
								end
							end
							OP_REPLACE: begin
								if (!acc_ok) begin
									rsp_q.status <= ST_ACC_REJ;
								end
							end
							OP_INSERT: begin
								if (!ins_ok) begin
									rsp_q.status <= ST_INS_REJ;
								end else if (tail_ins) begin
									cnt_q       <= cnt_q + CW'(1);
									rsp_q.count <= 8'(cnt_q + CW'(1));
								end else begin
									rsp_valid_q <= 1'b0;
									idx_q       <= AW'(cnt_m1);
									state_q     <= S_SHIFT;
								end
							end
							OP_DELETE: begin
								if (!acc_ok) begin
									rsp_q.status <= ST_ACC_REJ;
								end else if (tail_del) begin
									cnt_q       <= cnt_m1;
									rsp_q.count <= 8'(cnt_m1);
								end else begin
									rsp_valid_q <= 1'b0;
									idx_q       <= AW'(pos_c + CMPW'(1));
									state_q     <= S_SHIFT;
								end
							end
							OP_FIND: begin
								if (cnt_q == '0) begin
									rsp_q.status <= ST_NOT_FOUND;
								end else begin
									rsp_valid_q <= 1'b0;
									idx_q       <= '0;
									state_q     <= S_FIND;
								end
							end
							OP_CLEAR: begin
								cnt_q       <= '0;
								rsp_q.count <= '0;
							end
							default: begin
							end
						endcase
					end
				end
				S_RD_WAIT: begin
					rsp_q.read_value <= 32'(rd_data_s1);
					rsp_valid_q      <= 1'b1;
					state_q          <= S_IDLE;
				end
				S_SHIFT: begin
					shift_vld_s1 <= 1'b1;
					if (op_q == OP_INSERT) begin
						shift_waddr_s1 <= idx_q + AW'(1);
						if (idx_q == pos_q) begin
							state_q <= S_DRAIN;
						end else begin
							idx_q <= idx_q - AW'(1);
						end
					end else begin
						shift_waddr_s1 <= idx_q - AW'(1);
						if (CW'(idx_q) == cnt_m1) begin
							state_q <= S_DRAIN;
						end else begin
							idx_q <= idx_q + AW'(1);
						end
					end
				end
				S_DRAIN: begin
					if (op_q == OP_INSERT) begin
						state_q <= S_PUT;
					end else begin
						cnt_q       <= cnt_m1;
						rsp_q.count <= 8'(cnt_m1);
						rsp_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				S_PUT: begin
					cnt_q       <= cnt_q + CW'(1);
					rsp_q.count <= 8'(cnt_q + CW'(1));
					rsp_valid_q <= 1'b1;
					state_q     <= S_IDLE;
				end
				S_FIND: begin
					if (find_hit) begin
						rsp_q.found_position <= 7'(find_idx_s1);
						rsp_valid_q          <= 1'b1;
						state_q              <= S_IDLE;
					end else begin
						find_vld_s1 <= 1'b1;
						find_idx_s1 <= idx_q;
						idx_q       <= idx_q + AW'(1);
						if (CW'(idx_q) == cnt_m1) begin
							state_q <= S_FIND_LAST;
						end
					end
				end
				S_FIND_LAST: begin
					if (find_hit) begin
						rsp_q.found_position <= 7'(find_idx_s1);
					end else begin
						rsp_q.status <= ST_NOT_FOUND;
					end
					rsp_valid_q <= 1'b1;
					state_q     <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

@@ test/ale_checker.sv @@
// ----------------------------------------------------------------------------
// ale_checker
// Watches both channels of the array list engine. Each accepted request beat
// is applied to a private copy of the list to form the expected response
// beat. Each accepted response beat is compared field by field with the
// oldest expected beat. Mismatches, unexpected beats and the number of
// expected beats still waiting are passed to the testbench top.
// ----------------------------------------------------------------------------
`default_nettype none

module ale_checker (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              req_valid,
	input  wire logic              req_ready,
	input  wire ale_pkg::ale_req_t req_data,
	input  wire logic              rsp_valid,
	input  wire logic              rsp_ready,
	input  wire ale_pkg::ale_rsp_t rsp_data,
	output int                     fail_count,
	output int                     outstanding
);
	timeunit 1ns;
	timeprecision 1ps;

	import ale_pkg::*;

	logic [31:0] list_mem [ALE_CAPACITY];
	logic [7:0]  list_len;
	ale_rsp_t    pending_rsp [$];

	initial begin
		fail_count = 0;
		outstanding = 0;
		list_len = '0;
	end

	function automatic ale_rsp_t apply_request(ale_req_t r);
		ale_rsp_t o;
		int       i;
		o = '0;
		o.status = ST_OK;
		case (r.kind)
		OP_READ: begin
			if (r.position < list_len)
				o.read_value = list_mem[r.position];
			else
				o.status = ST_ACC_REJ;
		end
		OP_REPLACE: begin
			if (r.position < list_len)
				list_mem[r.position] = r.value;
			else
				o.status = ST_ACC_REJ;
		end
		OP_INSERT: begin
			if (list_len < ALE_CAPACITY && r.position <= list_len) begin
				for (i = list_len; i > r.position; i--)
					list_mem[i] = list_mem[i - 1];
				list_mem[r.position] = r.value;
				list_len++;
			end else begin
				o.status = ST_INS_REJ;
			end
		end
		OP_DELETE: begin
			if (r.position < list_len) begin
				for (i = r.position + 1; i < list_len; i++)
					list_mem[i - 1] = list_mem[i];
				list_len--;
			end else begin
				o.status = ST_ACC_REJ;
			end
		end
		OP_FIND: begin
			o.status = ST_NOT_FOUND;
			for (i = 0; i < list_len; i++) begin
				if (list_mem[i] == r.value) begin
					o.found_position = 7'(i);
					o.status = ST_OK;
					break;
				end
			end
		end
		OP_CLEAR: list_len = '0;
		default: ;
		endcase
		o.count = list_len;
		return o;
	endfunction

	task automatic compare_field(string name, logic [31:0] want, logic [31:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
			fail_count++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		ale_rsp_t want;
		if (!arst_n) begin
			list_len = '0;
			pending_rsp.delete();
			outstanding = 0;
		end else begin
			if (rsp_valid && rsp_ready) begin
				if (pending_rsp.size() == 0) begin
					$display("%0t: unexpected response beat, actual %p", $time, rsp_data);
					fail_count++;
				end else begin
					want = pending_rsp.pop_front();
					compare_field("read_value", want.read_value, rsp_data.read_value);
					compare_field("found_position", 32'(want.found_position),
						32'(rsp_data.found_position));
					compare_field("count", 32'(want.count), 32'(rsp_data.count));
					compare_field("status", 32'(want.status), 32'(rsp_data.status));
				end
			end
			if (req_valid && req_ready)
				pending_rsp.push_back(apply_request(req_data));
			outstanding = pending_rsp.size();
		end
	end

endmodule

`default_nettype wire

@@ test/tb_array_list_engine.sv @@
// ----------------------------------------------------------------------------
// tb_array_list_engine
// Drives the array list engine with a short directed sequence covering an empty
// list, rejected accesses, head, middle and tail moves, find hits
// and misses, clear and the unused operation codes, then with random runs
// that fill, shrink and mix the list. Both channels idle at random. The
// checker beside the block predicts and compares every response beat.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_array_list_engine;
	timeunit 1ns;
	timeprecision 1ps;

	import ale_pkg::*;

	localparam logic [2:0] KIND_SPARE_A = 3'd6;
	localparam logic [2:0] KIND_SPARE_B = 3'd7;
	localparam int ITEM_TARGET = 800;

	typedef enum int {MODE_FILL, MODE_GROW, MODE_SHRINK, MODE_MIXED} mix_t;

	logic     clk = 1'b0;
	logic     arst_n = 1'b0;
	logic     req_valid = 1'b0;
	logic     req_ready;
	ale_req_t req_data = '0;
	logic     rsp_valid;
	logic     rsp_ready = 1'b0;
	ale_rsp_t rsp_data;
	int       fail_count;
	int       outstanding;

	bit quiet = 1'b0;
	int stall_left = 0;
	int shadow_len = 0;
	int sent = 0;

	always #5 clk = ~clk;

	array_list_engine dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req_data  (req_data),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp_data  (rsp_data)
	);

	ale_checker u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.req_valid   (req_valid),
		.req_ready   (req_ready),
		.req_data    (req_data),
		.rsp_valid   (rsp_valid),
		.rsp_ready   (rsp_ready),
		.rsp_data    (rsp_data),
		.fail_count  (fail_count),
		.outstanding (outstanding)
	);

	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic logic [2:0] pick_kind(mix_t mode);
		int r;
		r = $urandom_range(0, 99);
		if (mode == MODE_FILL)
			return OP_INSERT;
		if (r >= 97)
			return $urandom_range(0, 1) ? KIND_SPARE_A : KIND_SPARE_B;
		if (r >= 95)
			return OP_CLEAR;
		case (mode)
		MODE_GROW: begin
			if (r < 55) return OP_INSERT;
			if (r < 65) return OP_READ;
			if (r < 75) return OP_REPLACE;
			if (r < 85) return OP_FIND;
			return OP_DELETE;
		end
		MODE_SHRINK: begin
			if (r < 55) return OP_DELETE;
			if (r < 65) return OP_INSERT;
			if (r < 75) return OP_READ;
			if (r < 85) return OP_REPLACE;
			return OP_FIND;
		end
		default: begin
			if (r < 18) return OP_READ;
			if (r < 36) return OP_REPLACE;
			if (r < 56) return OP_INSERT;
			if (r < 74) return OP_DELETE;
			return OP_FIND;
		end
		endcase
	endfunction

	function automatic logic [7:0] pick_position(logic [2:0] kind);
		if ($urandom_range(0, 9) == 0)
			return 8'($urandom_range(0, 255));
		if (kind == OP_INSERT)
			return 8'($urandom_range(0, shadow_len));
		if (shadow_len == 0)
			return 8'd0;
		return 8'($urandom_range(0, shadow_len - 1));
	endfunction

	function automatic logic [31:0] pick_value();
		case ($urandom_range(0, 9))
		0, 1, 2, 3, 4: return $urandom_range(0, 15);
		5: return -$urandom_range(1, 4);
		6: return $urandom_range(0, 1) ? 32'h7fff_ffff : 32'h8000_0000;
		default: return $urandom;
		endcase
	endfunction

	// sends one beat and keeps the list length as seen from the stimulus side, used only to aim positions
	task automatic send_beat(logic [2:0] kind, logic [7:0] pos, logic [31:0] value);
		int gap;
		gap = quiet ? 0 : gap_len();
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_valid <= 1'b1;
		req_data <= '{kind: kind, position: pos, value: value};
		@(posedge clk);
		while (!req_ready) @(posedge clk);
		case (kind)
		OP_INSERT: if (shadow_len < ALE_CAPACITY && pos <= shadow_len) shadow_len++;
		OP_DELETE: if (pos < shadow_len) shadow_len--;
		OP_CLEAR: shadow_len = 0;
		default: ;
		endcase
		sent++;
	endtask

	always @(posedge clk) begin
		if (!arst_n) begin
			rsp_ready <= 1'b0;
		end else if (stall_left > 0) begin
			stall_left--;
			rsp_ready <= 1'b0;
		end else if (quiet || $urandom_range(0, 3) != 0) begin
			rsp_ready <= 1'b1;
		end else begin
			stall_left = gap_len();
			rsp_ready <= 1'b0;
		end
	end

	initial begin
		#20_000_000;
		$display("array_list_engine test failed");
		$finish;
	end

	initial begin
		mix_t       mode;
		int         seg_len;
		logic [2:0] k;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty list
		send_beat(OP_READ, 8'd0, 32'd0);
		send_beat(OP_DELETE, 8'd0, 32'd0);
		send_beat(OP_REPLACE, 8'd0, 32'd9);
		send_beat(OP_FIND, 8'd0, 32'd0);
		send_beat(OP_INSERT, 8'd1, 32'd5);
		// head, tail and middle inserts
		send_beat(OP_INSERT, 8'd0, 32'h7fff_ffff);
		send_beat(OP_INSERT, 8'd1, 32'h8000_0000);
		send_beat(OP_INSERT, 8'd0, 32'hffff_ffff);
		send_beat(OP_INSERT, 8'd1, 32'd0);
		send_beat(OP_INSERT, 8'd128, 32'd1);
		// reads and finds
		send_beat(OP_READ, 8'd0, 32'd0);
		send_beat(OP_READ, 8'd3, 32'd0);
		send_beat(OP_READ, 8'd4, 32'd0);
		send_beat(OP_READ, 8'd255, 32'd0);
		send_beat(OP_FIND, 8'd0, 32'h8000_0000);
		send_beat(OP_FIND, 8'd0, 32'hffff_ffff);
		send_beat(OP_FIND, 8'd0, 32'd12345);
		// replace and delete
		send_beat(OP_REPLACE, 8'd2, 32'h5555_5555);
		send_beat(OP_REPLACE, 8'd4, 32'haaaa_aaaa);
		send_beat(OP_DELETE, 8'd1, 32'd0);
		send_beat(OP_DELETE, 8'd2, 32'd0);
		send_beat(OP_DELETE, 8'd255, 32'd0);
		// unused codes and clear
		send_beat(KIND_SPARE_A, 8'd255, 32'hffff_ffff);
		send_beat(KIND_SPARE_B, 8'd0, 32'd0);
		send_beat(OP_CLEAR, 8'd0, 32'd0);

		mode = MODE_FILL;
		while (sent < ITEM_TARGET) begin
			seg_len = (mode == MODE_FILL) ? 170 : $urandom_range(20, 60);
			quiet <= ($urandom_range(0, 4) == 0);
			repeat (seg_len) begin
				k = pick_kind(mode);
				send_beat(k, pick_position(k), pick_value());
			end
			mode = mix_t'($urandom_range(1, 3));
		end
		req_valid <= 1'b0;

		repeat (2) @(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (fail_count == 0)
			$display("array_list_engine test passed");
		else
			$display("array_list_engine test failed");
		$finish;
	end

endmodule

`default_nettype wire

@@ files.f @@
rtl/core/ale_pkg.sv
rtl/core/array_list_engine.sv
test/ale_checker.sv
test/tb_array_list_engine.sv
